### hdl/grid_ray_cast_hit_finder_defines.svh
// Assertion macros used by the checker file.
`ifndef GRID_RAY_CAST_HIT_FINDER_DEFINES_SVH
`define GRID_RAY_CAST_HIT_FINDER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/grc_pkg.sv
// Package: widths, codes and constants of the grid ray-cast hit finder.
package grc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CMD_W  = 2;
  localparam int PIX_W  = 10;
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int POS_W  = 21;
  localparam int CFG_W  = 11;
  localparam int DIM_W  = 13;
  localparam int CO_W   = 14;
  localparam int TIME_W = 40;
  localparam int QUO_W  = 25;
  localparam int DEN_W  = 21;
  localparam int LBL_W  = 2;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [LBL_W-1:0] LBL_RED   = 2'd0;
  localparam logic [LBL_W-1:0] LBL_GREEN = 2'd1;
  localparam logic [LBL_W-1:0] LBL_BLUE  = 2'd2;
  localparam logic [LBL_W-1:0] LBL_OTHER = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RST = 11'd1024;
  localparam logic [DIM_W-1:0] DIM_MIN = 13'd3;

  localparam logic [CH_W-1:0]  DARK_LIMIT   = 8'd3;
  localparam logic [CH_W-1:0]  BRIGHT_LIMIT = 8'd200;
  localparam logic [CH_W-1:0]  BRIGHT_STEP  = 8'd10;
  localparam logic [RGB_W-1:0] RGB_RED      = 24'hFF0000;
  localparam logic [RGB_W-1:0] RGB_GREEN    = 24'h00FF00;
  localparam logic [RGB_W-1:0] RGB_BLUE     = 24'h0000FF;

  localparam logic [QUO_W-1:0] TIME_ONE = 25'h1000000;

  typedef logic signed [CO_W-1:0] coord_t;
  localparam coord_t C_ZERO = '0;
  localparam coord_t C_ONE  = coord_t'(1);
  localparam coord_t C_TWO  = coord_t'(2);

  function automatic logic is_dark(input logic [RGB_W-1:0] p);
    return p[23:16] < DARK_LIMIT && p[15:8] < DARK_LIMIT && p[7:0] < DARK_LIMIT;
  endfunction

endpackage

### hdl/grc_if.sv
// Request and response channel interfaces.
interface grc_req_if;
  import grc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [PIX_W-1:0]         pixel_col;
  logic [PIX_W-1:0]         pixel_row;
  logic [CH_W-1:0]          pixel_red;
  logic [CH_W-1:0]          pixel_green;
  logic [CH_W-1:0]          pixel_blue;
  logic signed [POS_W-1:0]  start_x;
  logic signed [POS_W-1:0]  start_y;
  logic signed [POS_W-1:0]  end_x;
  logic signed [POS_W-1:0]  end_y;
  modport source (output valid, cmd, pixel_col, pixel_row, pixel_red, pixel_green,
                  pixel_blue, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, cmd, pixel_col, pixel_row, pixel_red, pixel_green,
                pixel_blue, start_x, start_y, end_x, end_y, output ready);
endinterface

interface grc_rsp_if;
  import grc_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [PIX_W-1:0] hit_col;
  logic [PIX_W-1:0] hit_row;
  logic [LBL_W-1:0] label;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  modport source (output valid, hit, hit_col, hit_row, label, out_red, out_green,
                  out_blue, input ready);
  modport sink (input valid, hit, hit_col, hit_row, label, out_red, out_green,
                out_blue, output ready);
endinterface

### hdl/grc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module grc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
)(
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/grc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module grc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [grc_pkg::QUO_W-1:0]  num,
  input  logic [grc_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [grc_pkg::QUO_W-1:0]  quo
);
  import grc_pkg::*;
  localparam int CNT_W = $clog2(QUO_W);

  logic [QUO_W-1:0] q;
  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] r_next;
  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_comb begin
    trial = {r, q[QUO_W-1]};
    if (trial >= {1'b0, den}) begin
      r_next = DEN_W'(trial - {1'b0, den});
      qbit   = 1'b1;
    end else begin
      r_next = trial[DEN_W-1:0];
      qbit   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        r    <= '0;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        r   <= r_next;
        q   <= {q[QUO_W-2:0], qbit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
endmodule

### hdl/grid_ray_cast_hit_finder.sv
// Grid ray-cast hit finder: input and output images in RAM, 2D grid ray walker.
// A load completes in the idle state; a read passes through S_RD and S_EMIT. A ray of
// nonzero length first runs a setup of four divisions on one serial divider, then for
// each grid cell crossed a RAM read (S_STEP) and an evaluate/write back (S_CHECK), then
// the 3x3 neighbourhood scan at the first non-black cell, then posts the response.
// Neither image is cleared after reset: a pixel reads back undefined until it is loaded.
module grid_ray_cast_hit_finder #(
  parameter int MAX_WIDTH  = grc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = grc_pkg::MAX_HEIGHT_DEF
)(
  input  logic                        clk,
  input  logic                        rst,
  grc_req_if.sink                     req,
  grc_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grc_pkg::APB_AW-1:0]  paddr,
  input  logic [grc_pkg::APB_DW-1:0]  pwdata,
  output logic [grc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import grc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = AW + DIM_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD       = 4'd1;
  localparam logic [3:0] S_DIV_GO   = 4'd2;
  localparam logic [3:0] S_DIV_WAIT = 4'd3;
  localparam logic [3:0] S_STEP     = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_NBR      = 4'd6;
  localparam logic [3:0] S_NBR_END  = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  function automatic logic [AW-1:0] addr_of(input logic [DIM_W-1:0] c,
                                             input logic [DIM_W-1:0] r);
    logic [MW-1:0] full;
    full = MW'(r) * MW'(MAX_WIDTH) + MW'(c);
    return full[AW-1:0];
  endfunction

  // configuration
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  coord_t           wl;
  coord_t           hl;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RST;
      image_height <= DIM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = APB_DW'(image_width);
      REG_HEIGHT: prdata = APB_DW'(image_height);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_comb begin
    if (DIM_W'(image_width) < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(image_width);
    end
    if (DIM_W'(image_height) < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (DIM_W'(image_height) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(image_height);
    end
  end

  assign wl = $signed({1'b0, w_eff});
  assign hl = $signed({1'b0, h_eff});

  // control and walk state
  logic [3:0]         state;
  coord_t             cx;
  coord_t             cy;
  logic [TIME_W-1:0]  tx;
  logic [TIME_W-1:0]  ty;
  logic [QUO_W-1:0]   dtx;
  logic [QUO_W-1:0]   dty;
  logic [DEN_W-1:0]   ax;
  logic [DEN_W-1:0]   ay;
  logic [8:0]         fnx;
  logic [8:0]         fny;
  logic               stx_pos;
  logic               sty_pos;
  logic [1:0]         div_sel;
  logic [1:0]         ni;
  logic [1:0]         nj;
  logic               pend;
  logic               near;
  logic               rd_ok;
  logic [RGB_W-1:0]   pix;
  logic [RGB_W-1:0]   opix;

  logic               res_hit;
  logic [PIX_W-1:0]   res_col;
  logic [PIX_W-1:0]   res_row;
  logic [LBL_W-1:0]   res_label;
  logic [RGB_W-1:0]   res_rgb;

  // request decode
  logic                      acc;
  logic                      req_ok;
  logic [AW-1:0]             req_addr;
  logic signed [POS_W:0]     dx;
  logic signed [POS_W:0]     dy;
  logic [POS_W:0]            adx;
  logic [POS_W:0]            ady;
  logic [CH_W-1:0]           fx;
  logic [CH_W-1:0]           fy;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign req_ok    = {3'b0, req.pixel_col} < DIM_W'(MAX_WIDTH) &&
                     {3'b0, req.pixel_row} < DIM_W'(MAX_HEIGHT);
  assign req_addr  = addr_of(DIM_W'(req.pixel_col), DIM_W'(req.pixel_row));

  always_comb begin
    dx  = {req.end_x[POS_W-1], req.end_x} - {req.start_x[POS_W-1], req.start_x};
    dy  = {req.end_y[POS_W-1], req.end_y} - {req.start_y[POS_W-1], req.start_y};
    adx = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
    ady = dy[POS_W] ? (POS_W+1)'(-dy) : dy;
    fx  = req.start_x[CH_W-1:0];
    fy  = req.start_y[CH_W-1:0];
  end

  // step logic
  logic   onx;
  coord_t nx;
  coord_t ny;
  logic   miss;

  always_comb begin
    onx = (ay == '0) || (ax != '0 && tx < ty);
    nx  = cx;
    ny  = cy;
    if (onx) begin
      nx = stx_pos ? cx + C_ONE : cx - C_ONE;
    end else begin
      ny = sty_pos ? cy + C_ONE : cy - C_ONE;
    end
    miss = onx ? (nx < C_ONE || nx > wl - C_TWO) : (ny < C_ONE || ny > hl - C_TWO);
    if (nx < C_ZERO || nx > wl - C_ONE || ny < C_ZERO || ny > hl - C_ONE) begin
      miss = 1'b1;
    end
  end

  // neighbourhood scan
  coord_t nbx;
  coord_t nby;
  logic   nb_inside;

  assign nbx       = cx + $signed(CO_W'(ni)) - C_ONE;
  assign nby       = cy + $signed(CO_W'(nj)) - C_ONE;
  assign nb_inside = nbx > C_ZERO && nby > C_ZERO && nbx < wl && nby < hl;

  // memories
  logic             in_we;
  logic [AW-1:0]    in_raddr;
  logic             in_re;
  logic [RGB_W-1:0] in_q;
  logic             out_we;
  logic [AW-1:0]    out_waddr;
  logic [RGB_W-1:0] out_wdata;
  logic             out_re;
  logic [AW-1:0]    out_raddr;
  logic [RGB_W-1:0] out_q;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    step_addr;
  logic             c_inside;
  logic             near_f;

  assign cur_addr  = addr_of(cx[DIM_W-1:0], cy[DIM_W-1:0]);
  assign step_addr = addr_of(nx[DIM_W-1:0], ny[DIM_W-1:0]);
  assign c_inside  = cx > C_ZERO && cy > C_ZERO;
  assign near_f    = near || (pend && is_dark(in_q));

  assign in_we    = acc && req.cmd == CMD_LOAD && req_ok;
  assign in_re    = (state == S_STEP && !miss) || (state == S_NBR && nb_inside);
  assign in_raddr = (state == S_STEP) ? step_addr
                                      : addr_of(nbx[DIM_W-1:0], nby[DIM_W-1:0]);

  assign out_re    = (state == S_STEP && !miss) || (acc && req.cmd == CMD_READ && req_ok);
  assign out_raddr = (state == S_STEP) ? step_addr : req_addr;

  always_comb begin
    out_we    = 1'b0;
    out_waddr = cur_addr;
    out_wdata = pix;
    if (state == S_IDLE) begin
      out_we    = in_we;
      out_waddr = req_addr;
      out_wdata = '0;
    end else if (state == S_CHECK) begin
      out_we    = !(c_inside && !is_dark(in_q)) && out_q[23:16] < BRIGHT_LIMIT;
      out_wdata = {out_q[23:16] + BRIGHT_STEP, out_q[15:8] + BRIGHT_STEP,
                   out_q[7:0] + BRIGHT_STEP};
    end else if (state == S_NBR_END) begin
      out_we    = near_f && opix != RGB_RED;
      out_wdata = pix;
    end
  end

  grc_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_in_ram (
    .clk(clk), .we(in_we), .waddr(req_addr),
    .wdata({req.pixel_red, req.pixel_green, req.pixel_blue}),
    .re(in_re), .raddr(in_raddr), .rdata(in_q)
  );

  grc_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_out_ram (
    .clk(clk), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
    .re(out_re), .raddr(out_raddr), .rdata(out_q)
  );

  // divider
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [QUO_W-1:0] div_quo;

  assign div_start = (state == S_DIV_GO);

  always_comb begin
    case (div_sel)
      2'd0:    div_num = TIME_ONE;
      2'd1:    div_num = {fnx, 16'b0};
      2'd2:    div_num = TIME_ONE;
      default: div_num = {fny, 16'b0};
    endcase
    div_den = div_sel[1] ? ay : ax;
  end

  grc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            res_hit   <= 1'b0;
            res_col   <= '0;
            res_row   <= '0;
            res_label <= LBL_OTHER;
            res_rgb   <= '0;
            rd_ok     <= req_ok;
            cx        <= {req.start_x[POS_W-1], req.start_x[POS_W-1:CH_W]};
            cy        <= {req.start_y[POS_W-1], req.start_y[POS_W-1:CH_W]};
            ax        <= adx[DEN_W-1:0];
            ay        <= ady[DEN_W-1:0];
            stx_pos   <= dx > 0;
            sty_pos   <= dy > 0;
            fnx       <= (dx > 0) ? 9'd256 - {1'b0, fx} : {1'b0, fx};
            fny       <= (dy > 0) ? 9'd256 - {1'b0, fy} : {1'b0, fy};
            div_sel   <= 2'd0;
            case (req.cmd)
              CMD_READ: state <= S_RD;
              CMD_RAY:  state <= (adx == '0 && ady == '0) ? S_EMIT : S_DIV_GO;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          res_rgb <= rd_ok ? out_q : '0;
          state   <= S_EMIT;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (div_sel)
              2'd0:    dtx <= div_quo;
              2'd1:    tx  <= TIME_W'(div_quo);
              2'd2:    dty <= div_quo;
              default: ty  <= TIME_W'(div_quo);
            endcase
            div_sel <= div_sel + 2'd1;
            state   <= (div_sel == 2'd3) ? S_STEP : S_DIV_GO;
          end
        end
        S_STEP: begin
          if (miss) begin
            state <= S_EMIT;
          end else begin
            cx <= nx;
            cy <= ny;
            if (onx) begin
              tx <= tx + TIME_W'(dtx);
            end else begin
              ty <= ty + TIME_W'(dty);
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (c_inside && !is_dark(in_q)) begin
            pix   <= in_q;
            opix  <= out_q;
            near  <= 1'b0;
            pend  <= 1'b0;
            ni    <= 2'd0;
            nj    <= 2'd0;
            state <= S_NBR;
          end else begin
            state <= S_STEP;
          end
        end
        S_NBR: begin
          pend <= nb_inside;
          if (pend && is_dark(in_q)) begin
            near <= 1'b1;
          end
          if (nj == 2'd2) begin
            nj <= 2'd0;
            ni <= ni + 2'd1;
          end else begin
            nj <= nj + 2'd1;
          end
          if (ni == 2'd2 && nj == 2'd2) begin
            state <= S_NBR_END;
          end
        end
        S_NBR_END: begin
          if (near_f && opix != RGB_RED) begin
            res_hit <= 1'b1;
            res_col <= cx[PIX_W-1:0];
            res_row <= cy[PIX_W-1:0];
            if (pix == RGB_RED) begin
              res_label <= LBL_RED;
            end else if (pix == RGB_GREEN) begin
              res_label <= LBL_GREEN;
            end else if (pix == RGB_BLUE) begin
              res_label <= LBL_BLUE;
            end else begin
              res_label <= LBL_OTHER;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response register
  logic emit;
  assign emit = (state == S_EMIT) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.hit       <= res_hit;
      rsp.hit_col   <= res_col;
      rsp.hit_row   <= res_row;
      rsp.label     <= res_label;
      rsp.out_red   <= res_rgb[23:16];
      rsp.out_green <= res_rgb[15:8];
      rsp.out_blue  <= res_rgb[7:0];
    end
  end
endmodule

### hdl/grc_checker.sv
// Port-level checker for the grid ray-cast hit finder and its bind.
`include "grid_ray_cast_hit_finder_defines.svh"

module grc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [grc_pkg::CMD_W-1:0]   req_cmd,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_hit,
  input logic [grc_pkg::PIX_W-1:0]   rsp_hit_col,
  input logic [grc_pkg::PIX_W-1:0]   rsp_hit_row,
  input logic [grc_pkg::LBL_W-1:0]   rsp_label,
  input logic [grc_pkg::CH_W-1:0]    rsp_red,
  input logic [grc_pkg::CH_W-1:0]    rsp_green,
  input logic [grc_pkg::CH_W-1:0]    rsp_blue
);
  import grc_pkg::*;

  `GRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `GRC_ASSERT_SAME(a_miss_zero, rsp_valid && !rsp_hit, rsp_hit_col == '0 && rsp_hit_row == '0 && rsp_label == LBL_OTHER, "miss or read carries a cell")
  `GRC_ASSERT_SAME(a_hit_color, rsp_valid && rsp_hit, rsp_red == '0 && rsp_green == '0 && rsp_blue == '0, "hit carries colour")
  `GRC_ASSERT_NEXT(a_load_silent, req_valid && req_ready && req_cmd == CMD_LOAD && !rsp_valid, !rsp_valid, "load produced a response")
endmodule

bind grid_ray_cast_hit_finder grc_checker u_grc_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready), .req_cmd(req.cmd),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
  .rsp_hit_col(rsp.hit_col), .rsp_hit_row(rsp.hit_row), .rsp_label(rsp.label),
  .rsp_red(rsp.out_red), .rsp_green(rsp.out_green), .rsp_blue(rsp.out_blue)
);
